>>> sv/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// Shared widths, codes and controller/datapath interface types for the
// geometric rollup split block.
// ----------------------------------------------------------------------------
package grs_pkg;

   localparam int WEIGHT_W    = 32;
   localparam int FACTOR_W    = 16;
   localparam int FLAG_W      = 3;
   localparam int WORD_W      = WEIGHT_W + FLAG_W;
   localparam int TOTAL_W     = WEIGHT_W + 1;
   localparam int PROD_W      = FACTOR_W + TOTAL_W;
   localparam int SPLIT_W     = 11;
   localparam int PREF_W      = 10;
   localparam int ERR_W       = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // flag bit positions inside the flag field of a stored entry
   localparam int FLAG_BAD   = 0;
   localparam int FLAG_LOCAL = 1;
   localparam int FLAG_INDEX = 2;

   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [ERR_W-1:0] ERR_ORDER    = 2'd2;
   localparam logic [ERR_W-1:0] ERR_COUNT    = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_GROWTH_FACTOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEMOTE_ENABLE = 1'd1;

   localparam logic [FACTOR_W-1:0] GROWTH_FACTOR_RESET = 16'd2;
   localparam logic                DEMOTE_ENABLE_RESET = 1'b1;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_START,
      OP_BACK_CUR,
      OP_BACK_PREV,
      OP_BACK_MUL,
      OP_BACK_CHECK,
      OP_SUM_READ,
      OP_SUM_ADD,
      OP_GROW_READ,
      OP_GROW_CHECK,
      OP_DEMOTE_INIT,
      OP_DEMOTE_READ,
      OP_DEMOTE_EVAL,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } grs_cmd_type;

   typedef struct packed {
      logic faulted;
      logic single;
      logic overflow;
      logic less;
      logic i_one;
      logic sum_done;
      logic k_end;
   } grs_status_type;

endpackage

>>> sv/grs_ram.sv
// ----------------------------------------------------------------------------
// grs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module grs_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/grs_datapath.sv
// ----------------------------------------------------------------------------
// grs_datapath
// Entry store, scan counters, shared factor multiplier, running total,
// configuration registers and result registers.
// ----------------------------------------------------------------------------
module grs_datapath #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  grs_pkg::grs_cmd_type              cmd,
   output grs_pkg::grs_status_type           status,
   input  logic [grs_pkg::WEIGHT_W-1:0]      req_weight,
   input  logic                              req_bad_deltas,
   input  logic                              req_is_local,
   input  logic                              req_in_index,
   input  logic                              csr_we,
   input  logic [grs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [grs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [grs_pkg::SPLIT_W-1:0]       rsp_split_count,
   output logic [grs_pkg::PREF_W-1:0]        rsp_preferred_index,
   output logic                              rsp_preferred_found,
   output logic                              rsp_tip_rewritten,
   output logic [grs_pkg::ERR_W-1:0]         rsp_error_code
);

   import grs_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);
   localparam logic [CW-1:0] ONE       = CW'(1);
   localparam logic [CW-1:0] TWO       = CW'(2);

   // control state
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                order_fault_ff, order_fault_in;
   logic                count_fault_ff, count_fault_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic                demote_ff, demote_in;
   logic                ovf_ff, ovf_in;

   // scan state
   logic [WEIGHT_W-1:0] last_w_ff, last_w_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [CW-1:0]       split_ff, split_in;
   logic [CW-1:0]       demoted_ff, demoted_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [WEIGHT_W-1:0] cur_ff, cur_in;
   logic [WEIGHT_W-1:0] prev_ff, prev_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                tip_ff, tip_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       pref_ff, pref_in;

   // result
   logic [SPLIT_W-1:0]  out_split_ff, out_split_in;
   logic [PREF_W-1:0]   out_pref_ff, out_pref_in;
   logic                out_found_ff, out_found_in;
   logic                out_tip_ff, out_tip_in;
   logic [ERR_W-1:0]    out_err_ff, out_err_in;

   logic                wr_en;
   logic [AW-1:0]       rd_addr;
   logic [WORD_W-1:0]   rd_data;
   logic [WEIGHT_W-1:0] rd_word;
   logic [FLAG_W-1:0]   rd_flags;
   logic [CW-1:0]       i_dec, i_dec2, i_inc, k_inc, cnt_dec;
   logic [TOTAL_W-1:0]  mul_b;
   logic [TOTAL_W:0]    sum_wide;
   logic [TOTAL_W-1:0]  total_add;
   logic [WEIGHT_W-1:0] cmp_a;
   logic                demote_hit;
   logic [ERR_W-1:0]    err;

   grs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_grs_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data ({req_in_index, req_is_local, req_bad_deltas, req_weight}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_word  = rd_data[WEIGHT_W-1:0];
   assign rd_flags = rd_data[WORD_W-1:WEIGHT_W];

   assign i_dec   = i_ff - ONE;
   assign i_dec2  = i_ff - TWO;
   assign i_inc   = i_ff + ONE;
   assign k_inc   = k_ff + ONE;
   assign cnt_dec = cnt_ff - ONE;

   assign wr_en = (cmd.op == OP_LOAD) && (cnt_ff < MAX_COUNT);

   always_comb begin
      case (cmd.op)
         OP_BACK_CUR:   rd_addr = i_ff[AW-1:0];
         OP_BACK_PREV:  rd_addr = i_dec[AW-1:0];
         OP_BACK_CHECK: rd_addr = i_dec2[AW-1:0];
         default:       rd_addr = k_ff[AW-1:0];
      endcase
   end

   // one shared multiplier: factor times entry weight or times running total
   assign mul_b = (cmd.op == OP_GROW_READ) ? total_ff : {1'b0, rd_word};

   // running total clamps to 2**32 once the sum carries out of its 33 bits
   assign sum_wide  = {1'b0, total_ff} + (TOTAL_W + 1)'(rd_word);
   assign total_add = sum_wide[TOTAL_W] ? {1'b1, {WEIGHT_W{1'b0}}} : sum_wide[TOTAL_W-1:0];

   assign cmp_a      = (cmd.op == OP_GROW_CHECK) ? rd_word : cur_ff;
   assign demote_hit = demote_ff & rd_flags[FLAG_BAD];

   assign status.faulted  = order_fault_ff | count_fault_ff;
   assign status.single   = (cnt_ff == ONE);
   assign status.overflow = |prod_ff[PROD_W-1:WEIGHT_W];
   assign status.less     = (cmp_a < prod_ff[WEIGHT_W-1:0]);
   assign status.i_one    = (i_ff == ONE);
   assign status.sum_done = (k_inc == split_ff);
   assign status.k_end    = (k_ff == cnt_ff);

   always_comb begin
      if (count_fault_ff) begin
         err = ERR_COUNT;
      end else if (order_fault_ff) begin
         err = ERR_ORDER;
      end else if (ovf_ff) begin
         err = ERR_OVERFLOW;
      end else begin
         err = ERR_OK;
      end
   end

   always_comb begin
      cnt_in         = cnt_ff;
      order_fault_in = order_fault_ff;
      count_fault_in = count_fault_ff;
      factor_in      = factor_ff;
      demote_in      = demote_ff;
      ovf_in         = ovf_ff;
      last_w_in      = last_w_ff;
      i_in           = i_ff;
      k_in           = k_ff;
      split_in       = split_ff;
      demoted_in     = demoted_ff;
      total_in       = total_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      prod_in        = prod_ff;
      tip_in         = tip_ff;
      found_in       = found_ff;
      pref_in        = pref_ff;
      out_split_in   = out_split_ff;
      out_pref_in    = out_pref_ff;
      out_found_in   = out_found_ff;
      out_tip_in     = out_tip_ff;
      out_err_in     = out_err_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_GROWTH_FACTOR: factor_in = csr_wdata[FACTOR_W-1:0];
            CSR_DEMOTE_ENABLE: demote_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            if (cnt_ff < MAX_COUNT) begin
               if ((cnt_ff != '0) && (req_weight < last_w_ff)) begin
                  order_fault_in = 1'b1;
               end
               last_w_in = req_weight;
               cnt_in    = cnt_ff + ONE;
            end else begin
               count_fault_in = 1'b1;
            end
         end
         OP_START: begin
            i_in     = cnt_dec;
            k_in     = '0;
            split_in = '0;
            total_in = '0;
            ovf_in   = 1'b0;
         end
         OP_BACK_PREV: begin
            cur_in = rd_word;
         end
         OP_BACK_MUL: begin
            prev_in = rd_word;
            prod_in = PROD_W'(factor_ff) * PROD_W'(mul_b);
         end
         OP_BACK_CHECK: begin
            if (status.overflow) begin
               ovf_in = 1'b1;
            end else if (status.less) begin
               split_in = i_inc;
            end else begin
               cur_in = prev_ff;
               i_in   = i_dec;
            end
         end
         OP_SUM_ADD: begin
            total_in = total_add;
            k_in     = k_inc;
         end
         OP_GROW_READ: begin
            prod_in = PROD_W'(factor_ff) * PROD_W'(mul_b);
         end
         OP_GROW_CHECK: begin
            if (status.overflow) begin
               ovf_in = 1'b1;
            end else if (status.less) begin
               split_in = split_ff + ONE;
               total_in = total_add;
               k_in     = k_inc;
            end
         end
         OP_DEMOTE_INIT: begin
            k_in       = '0;
            demoted_in = '0;
            tip_in     = 1'b0;
            found_in   = 1'b0;
            pref_in    = '0;
         end
         OP_DEMOTE_EVAL: begin
            if (k_ff < split_ff) begin
               if (rd_flags[FLAG_INDEX]) begin
                  tip_in = 1'b1;
               end
            end else if (demote_hit) begin
               demoted_in = demoted_ff + ONE;
               if (rd_flags[FLAG_INDEX]) begin
                  tip_in = 1'b1;
               end
            end else if (rd_flags[FLAG_LOCAL]) begin
               found_in = 1'b1;
               pref_in  = k_ff[AW-1:0];
            end
            k_in = k_inc;
         end
         OP_FINISH: begin
            out_err_in = err;
            if (err == ERR_OK) begin
               out_split_in = SPLIT_W'(split_ff + demoted_ff);
               out_pref_in  = PREF_W'(pref_ff);
               out_found_in = found_ff;
               out_tip_in   = tip_ff;
            end else begin
               out_split_in = '0;
               out_pref_in  = '0;
               out_found_in = 1'b0;
               out_tip_in   = 1'b0;
            end
            cnt_in         = '0;
            order_fault_in = 1'b0;
            count_fault_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         order_fault_ff <= 1'b0;
         count_fault_ff <= 1'b0;
         factor_ff      <= GROWTH_FACTOR_RESET;
         demote_ff      <= DEMOTE_ENABLE_RESET;
         ovf_ff         <= 1'b0;
      end else begin
         cnt_ff         <= cnt_in;
         order_fault_ff <= order_fault_in;
         count_fault_ff <= count_fault_in;
         factor_ff      <= factor_in;
         demote_ff      <= demote_in;
         ovf_ff         <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      last_w_ff    <= last_w_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      split_ff     <= split_in;
      demoted_ff   <= demoted_in;
      total_ff     <= total_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prod_ff      <= prod_in;
      tip_ff       <= tip_in;
      found_ff     <= found_in;
      pref_ff      <= pref_in;
      out_split_ff <= out_split_in;
      out_pref_ff  <= out_pref_in;
      out_found_ff <= out_found_in;
      out_tip_ff   <= out_tip_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_split_count     = out_split_ff;
   assign rsp_preferred_index = out_pref_ff;
   assign rsp_preferred_found = out_found_ff;
   assign rsp_tip_rewritten   = out_tip_ff;
   assign rsp_error_code      = out_err_ff;

endmodule

>>> sv/grs_controller.sv
// ----------------------------------------------------------------------------
// grs_controller
// Sequencer for load, backward ratio scan, prefix sum, forward growth,
// demotion scan and result hand-off.
// ----------------------------------------------------------------------------
module grs_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output grs_pkg::grs_cmd_type    cmd,
   input  grs_pkg::grs_status_type status
);

   import grs_pkg::*;

   typedef enum logic [3:0] {
      S_LOAD,
      S_START,
      S_BACK_CUR,
      S_BACK_PREV,
      S_BACK_MUL,
      S_BACK_CHECK,
      S_SUM_READ,
      S_SUM_ADD,
      S_GROW_READ,
      S_GROW_CHECK,
      S_DEMOTE_INIT,
      S_DEMOTE_READ,
      S_DEMOTE_EVAL,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;
   logic      out_free;

   assign req_stall  = (state_ff != S_LOAD);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               cmd.op = OP_LOAD;
               if (req_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cmd.op = OP_START;
            if (status.faulted) begin
               state_in = S_FINISH;
            end else if (status.single) begin
               state_in = S_GROW_READ;
            end else begin
               state_in = S_BACK_CUR;
            end
         end
         S_BACK_CUR: begin
            cmd.op   = OP_BACK_CUR;
            state_in = S_BACK_PREV;
         end
         S_BACK_PREV: begin
            cmd.op   = OP_BACK_PREV;
            state_in = S_BACK_MUL;
         end
         S_BACK_MUL: begin
            cmd.op   = OP_BACK_MUL;
            state_in = S_BACK_CHECK;
         end
         S_BACK_CHECK: begin
            cmd.op = OP_BACK_CHECK;
            if (status.overflow) begin
               state_in = S_FINISH;
            end else if (status.less) begin
               state_in = S_SUM_READ;
            end else if (status.i_one) begin
               state_in = S_GROW_READ;
            end else begin
               state_in = S_BACK_MUL;
            end
         end
         S_SUM_READ: begin
            cmd.op   = OP_SUM_READ;
            state_in = S_SUM_ADD;
         end
         S_SUM_ADD: begin
            cmd.op = OP_SUM_ADD;
            if (status.sum_done) begin
               state_in = S_GROW_READ;
            end else begin
               state_in = S_SUM_READ;
            end
         end
         S_GROW_READ: begin
            cmd.op = OP_GROW_READ;
            if (status.k_end) begin
               state_in = S_DEMOTE_INIT;
            end else begin
               state_in = S_GROW_CHECK;
            end
         end
         S_GROW_CHECK: begin
            cmd.op = OP_GROW_CHECK;
            if (status.overflow) begin
               state_in = S_FINISH;
            end else if (status.less) begin
               state_in = S_GROW_READ;
            end else begin
               state_in = S_DEMOTE_INIT;
            end
         end
         S_DEMOTE_INIT: begin
            cmd.op   = OP_DEMOTE_INIT;
            state_in = S_DEMOTE_READ;
         end
         S_DEMOTE_READ: begin
            cmd.op = OP_DEMOTE_READ;
            if (status.k_end) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_DEMOTE_EVAL;
            end
         end
         S_DEMOTE_EVAL: begin
            cmd.op   = OP_DEMOTE_EVAL;
            state_in = S_DEMOTE_READ;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.op   = OP_FINISH;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_FINISH) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/geometric_rollup_split.sv
// ----------------------------------------------------------------------------
// geometric_rollup_split
// Loads an ascending list of entry weights and flags, then computes the
// rollup split, the preferred kept entry and the tip rewrite flag.
// ----------------------------------------------------------------------------
// loading: items load at one per cycle while req_stall is low; after the last item
//   the block walks B entries down, sums S, grows G and scans all N entries in the
//   list, all through one shared RAM read port
// throughput: one list at a time; the next list loads while a result waits
// reset: synchronous, clears the entry count, faults and result valid and
//   restores growth_factor to 2 and demote_enable to 1; no clearing pass
module geometric_rollup_split #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [grs_pkg::WEIGHT_W-1:0]      req_weight,
   input  logic                              req_bad_deltas,
   input  logic                              req_is_local,
   input  logic                              req_in_index,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [grs_pkg::SPLIT_W-1:0]       rsp_split_count,
   output logic [grs_pkg::PREF_W-1:0]        rsp_preferred_index,
   output logic                              rsp_preferred_found,
   output logic                              rsp_tip_rewritten,
   output logic [grs_pkg::ERR_W-1:0]         rsp_error_code,
   input  logic                              csr_we,
   input  logic [grs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [grs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import grs_pkg::*;

   grs_cmd_type    cmd;
   grs_status_type status;

   grs_controller u_grs_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   grs_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_grs_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_weight          (req_weight),
      .req_bad_deltas      (req_bad_deltas),
      .req_is_local        (req_is_local),
      .req_in_index        (req_in_index),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_split_count     (rsp_split_count),
      .rsp_preferred_index (rsp_preferred_index),
      .rsp_preferred_found (rsp_preferred_found),
      .rsp_tip_rewritten   (rsp_tip_rewritten),
      .rsp_error_code      (rsp_error_code)
   );

endmodule

>>> sv/grs_checker.sv
// ----------------------------------------------------------------------------
// grs_checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module grs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [grs_pkg::SPLIT_W-1:0] rsp_split_count,
   input logic [grs_pkg::PREF_W-1:0]  rsp_preferred_index,
   input logic                        rsp_preferred_found,
   input logic                        rsp_tip_rewritten,
   input logic [grs_pkg::ERR_W-1:0]   rsp_error_code
);

   import grs_pkg::*;

   // a stalled item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled item keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_split_count) && $stable(rsp_preferred_index)
         && $stable(rsp_preferred_found) && $stable(rsp_tip_rewritten)
         && $stable(rsp_error_code))
      else $error("rsp payload changed while stalled");

   // an error result carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_OK) |-> (rsp_split_count == '0)
         && (rsp_preferred_index == '0) && !rsp_preferred_found && !rsp_tip_rewritten)
      else $error("error result with nonzero fields");

   // no preferred entry means index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_preferred_found |-> (rsp_preferred_index == '0))
      else $error("preferred index set without preferred entry");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind geometric_rollup_split grs_checker u_grs_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for geometric_rollup_split
// Loads entry lists through the request channel and checks every result
// against a local model of the ladder split, demotion and preferred entry
// search. Directed lists cover weight extremes, order and overflow errors,
// a zero factor and single entries. Random lists follow under several
// register settings. An oversized list exercises the entry limit.
// ----------------------------------------------------------------------------
module testbench;
   import grs_pkg::*;

   localparam int MAX_ENTRIES = 1024;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES = 1500;
   localparam longint unsigned WORD_MAX = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [SPLIT_W-1:0] split_count;
      logic [PREF_W-1:0]  preferred_index;
      logic               preferred_found;
      logic               tip_rewritten;
      logic [ERR_W-1:0]   error_code;
   } split_result_type;

   class split_scoreboard;
      logic [WEIGHT_W-1:0] weights [MAX_ENTRIES];
      logic [FLAG_W-1:0]   flags [MAX_ENTRIES];
      int unsigned         entry_count = 0;
      bit                  order_fault = 0;
      bit                  count_fault = 0;
      logic [FACTOR_W-1:0] growth_factor = GROWTH_FACTOR_RESET;
      logic                demote_enable = DEMOTE_ENABLE_RESET;
      split_result_type    expected_splits [$];
      int                  failures = 0;

      // split before demotion: top ladder walk, then rollup growth
      function int ladder_split(int n, output bit overflow);
         longint unsigned factor, prod, total;
         int i, k, split;
         factor = 64'(growth_factor);
         total = 0;
         overflow = 0;
         if (n == 0)
            return 0;
         for (i = n - 1; i > 0; i--) begin
            prod = factor * weights[i-1];
            if (prod > WORD_MAX) begin
               overflow = 1;
               return 0;
            end
            if (weights[i] < prod)
               break;
         end
         split = (i == 0) ? 0 : i + 1;
         for (k = 0; k < split; k++)
            total += weights[k];
         for (i = split; i < n; i++) begin
            prod = factor * total;
            if (prod > WORD_MAX) begin
               overflow = 1;
               return 0;
            end
            if (weights[i] < prod) begin
               split++;
               total += weights[i];
            end else begin
               break;
            end
         end
         return split;
      endfunction

      function void note_entry(logic [WEIGHT_W-1:0] weight, logic [FLAG_W-1:0] entry_flags,
                               logic is_last);
         split_result_type res;
         int split, demoted, k;
         bit overflow;
         res = '0;
         split = 0;
         demoted = 0;
         overflow = 0;
         if (entry_count < MAX_ENTRIES) begin
            if (entry_count > 0 && weight < weights[entry_count-1])
               order_fault = 1;
            weights[entry_count] = weight;
            flags[entry_count] = entry_flags;
            entry_count++;
         end else begin
            count_fault = 1;
         end
         if (!is_last)
            return;
         if (count_fault) begin
            res.error_code = ERR_COUNT;
         end else if (order_fault) begin
            res.error_code = ERR_ORDER;
         end else begin
            split = ladder_split(entry_count, overflow);
            if (overflow)
               res.error_code = ERR_OVERFLOW;
         end
         if (res.error_code == ERR_OK) begin
            for (k = 0; k < split; k++)
               if (flags[k][FLAG_INDEX])
                  res.tip_rewritten = 1'b1;
            for (k = split; k < int'(entry_count); k++) begin
               if (demote_enable && flags[k][FLAG_BAD]) begin
                  demoted++;
                  if (flags[k][FLAG_INDEX])
                     res.tip_rewritten = 1'b1;
               end
            end
            for (k = int'(entry_count) - 1; k >= split; k--) begin
               if (demote_enable && flags[k][FLAG_BAD])
                  continue;
               if (flags[k][FLAG_LOCAL]) begin
                  res.preferred_found = 1'b1;
                  res.preferred_index = PREF_W'(k);
                  break;
               end
            end
            res.split_count = SPLIT_W'(split + demoted);
         end
         expected_splits.push_back(res);
         entry_count = 0;
         order_fault = 0;
         count_fault = 0;
      endfunction

      function void compare_field(string field, logic [SPLIT_W-1:0] want,
                                  logic [SPLIT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(split_result_type got);
         split_result_type want;
         if (expected_splits.size() == 0) begin
            $error("result with no list pending: split_count %0d, error_code %0d",
                   got.split_count, got.error_code);
            failures++;
            return;
         end
         want = expected_splits.pop_front();
         compare_field("split_count", want.split_count, got.split_count);
         compare_field("preferred_index", SPLIT_W'(want.preferred_index),
                       SPLIT_W'(got.preferred_index));
         compare_field("preferred_found", SPLIT_W'(want.preferred_found),
                       SPLIT_W'(got.preferred_found));
         compare_field("tip_rewritten", SPLIT_W'(want.tip_rewritten),
                       SPLIT_W'(got.tip_rewritten));
         compare_field("error_code", SPLIT_W'(want.error_code), SPLIT_W'(got.error_code));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [WEIGHT_W-1:0]    req_weight;
   logic                   req_bad_deltas;
   logic                   req_is_local;
   logic                   req_in_index;
   logic                   req_last;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [SPLIT_W-1:0]     rsp_split_count;
   logic [PREF_W-1:0]      rsp_preferred_index;
   logic                   rsp_preferred_found;
   logic                   rsp_tip_rewritten;
   logic [ERR_W-1:0]       rsp_error_code;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   split_scoreboard sb = new;
   int cycle_count = 0;
   int req_style;
   int rsp_style;
   bit req_burst;
   bit rsp_hold_pending;

   geometric_rollup_split #(.MAX_ENTRIES(MAX_ENTRIES)) u_top (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_entry(req_weight, {req_in_index, req_is_local, req_bad_deltas}, req_last);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(split_result_type'({rsp_split_count, rsp_preferred_index,
                                             rsp_preferred_found, rsp_tip_rewritten,
                                             rsp_error_code}));
   end

   // idle style changes now and then: none, sparse, or dense gaps
   function automatic int draw_gap(inout int style);
      if ($urandom_range(0, 31) == 0)
         style = $urandom_range(0, 2);
      case (style)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
         default: return $urandom_range(0, 18);
      endcase
   endfunction

   // result side
   initial begin
      int gap;
      rsp_stall = 1'b0;
      rsp_style = 1;
      do @(posedge clock); while (reset);
      forever begin
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (rsp_hold_pending) begin
            gap = HOLD_CYCLES;
            rsp_hold_pending = 0;
         end else begin
            gap = draw_gap(rsp_style);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_entry(logic [WEIGHT_W-1:0] weight, logic [FLAG_W-1:0] entry_flags,
                             logic is_last);
      int gap;
      gap = req_burst ? 0 : draw_gap(req_style);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_weight <= weight;
      req_bad_deltas <= entry_flags[FLAG_BAD];
      req_is_local <= entry_flags[FLAG_LOCAL];
      req_in_index <= entry_flags[FLAG_INDEX];
      req_last <= is_last;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_splits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(logic [FACTOR_W-1:0] factor, logic demote);
      wait_drained();
      write_csr(CSR_GROWTH_FACTOR, factor);
      write_csr(CSR_DEMOTE_ENABLE, {{(CSR_DATA_W-1){1'b0}}, demote});
      sb.growth_factor = factor;
      sb.demote_enable = demote;
   endtask

   // shape 0: ascending list, 1: one descending step, 2: unsorted noise
   task automatic send_random_list(int len, int shape);
      longint unsigned prev, cand, span, factor;
      int bad_pos, j;
      factor = 64'(sb.growth_factor);
      bad_pos = $urandom_range(1, (len > 1) ? len - 1 : 1);
      prev = 0;
      for (j = 0; j < len; j++) begin
         if (shape == 2) begin
            cand = 64'($urandom);
         end else if (j == 0) begin
            cand = $urandom_range(0, 1) ? 64'($urandom_range(0, 15))
                                        : 64'($urandom >> $urandom_range(0, 31));
         end else if (shape == 1 && j == bad_pos && prev > 0) begin
            cand = prev - 1 - ($urandom % prev);
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2: cand = prev;
               3, 4, 5, 6, 7: cand = prev + $urandom_range(0, 3);
               8, 9, 10, 11, 12, 13, 14, 15, 16: begin
                  // land just under, on, or just over the ladder step
                  cand = prev * factor;
                  if ($urandom_range(0, 1) && cand > 0)
                     cand = cand - 1;
                  else
                     cand = cand + $urandom_range(0, 2);
               end
               default: begin
                  span = WORD_MAX - prev;
                  cand = prev + ({$urandom, $urandom} % (span + 1));
               end
            endcase
            if (cand < prev)
               cand = prev;
            if (cand > WORD_MAX)
               cand = WORD_MAX;
         end
         send_entry(cand[WEIGHT_W-1:0], FLAG_W'($urandom_range(0, 7)), j == len - 1);
         prev = cand;
      end
   endtask

   task automatic run_phase(logic [FACTOR_W-1:0] factor, logic demote, int budget,
                            bit pressure);
      int sent, len, shape;
      apply_settings(factor, demote);
      sent = 0;
      if (pressure) begin
         rsp_hold_pending = 1;
         req_burst = 1;
      end
      while (sent < budget) begin
         if (req_burst && sent >= 60)
            req_burst = 0;
         case ($urandom_range(0, 19))
            0: shape = 2;
            1, 2: shape = 1;
            default: shape = 0;
         endcase
         if (req_burst) begin
            len = $urandom_range(1, 3);
         end else begin
            case ($urandom_range(0, 19))
               0: len = $urandom_range(25, 64);
               1, 2, 3, 4, 5: len = $urandom_range(9, 24);
               default: len = $urandom_range(1, 8);
            endcase
         end
         send_random_list(len, shape);
         sent += len;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_weight = '0;
      req_bad_deltas = 1'b0;
      req_is_local = 1'b0;
      req_in_index = 1'b0;
      req_last = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_style = 1;
      req_burst = 0;
      rsp_hold_pending = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single entries at the weight extremes
      send_entry(32'hFFFF_FFFF, 3'b111, 1'b1);
      send_entry(32'h0000_0000, 3'b010, 1'b1);
      // clean ladder
      send_entry(32'd1, 3'b100, 1'b0);
      send_entry(32'd2, 3'b011, 1'b0);
      send_entry(32'd4, 3'b010, 1'b0);
      send_entry(32'd8, 3'b001, 1'b1);
      // descending list that would also overflow: order error wins
      send_entry(32'h9000_0000, 3'b000, 1'b0);
      send_entry(32'h8000_0000, 3'b110, 1'b0);
      send_entry(32'hFFFF_FFFF, 3'b001, 1'b1);
      // overflow on the top walk
      send_entry(32'h8000_0000, 3'b010, 1'b0);
      send_entry(32'hFFFF_FFFF, 3'b010, 1'b1);
      // overflow while growing the rollup
      send_entry(32'h6000_0000, 3'b100, 1'b0);
      send_entry(32'h6000_0000, 3'b011, 1'b0);
      send_entry(32'hC000_0000, 3'b110, 1'b1);
      // rollup grows through the low entries
      send_entry(32'd3, 3'b000, 1'b0);
      send_entry(32'd3, 3'b101, 1'b0);
      send_entry(32'd3, 3'b010, 1'b0);
      send_entry(32'd10, 3'b011, 1'b0);
      send_entry(32'd100, 3'b110, 1'b1);
      // zero factor: only demoted entries roll up
      apply_settings(16'd0, 1'b1);
      send_entry(32'd7, 3'b001, 1'b0);
      send_entry(32'd9, 3'b110, 1'b0);
      send_entry(32'd11, 3'b101, 1'b1);
      // largest factor, demotion off
      apply_settings(16'hFFFF, 1'b0);
      send_entry(32'd1, 3'b011, 1'b0);
      send_entry(32'd65535, 3'b101, 1'b0);
      send_entry(32'hFFFE_0001, 3'b111, 1'b1);

      run_phase(16'd2, 1'b1, 90, 1'b0);
      run_phase(16'd1, 1'b0, 90, 1'b0);
      run_phase(16'd3, 1'b1, 90, 1'b1);
      run_phase(16'hFFFF, 1'b1, 90, 1'b0);
      run_phase(16'd0, 1'b0, 90, 1'b0);
      run_phase(FACTOR_W'($urandom_range(2, 16)), 1'($urandom_range(0, 1)), 90, 1'b0);
      run_phase(16'd4, 1'b0, 90, 1'b0);

      // one list past the entry limit
      apply_settings(16'd1, 1'b1);
      send_random_list(MAX_ENTRIES + 2, 1);
      wait_drained();

      if (sb.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
